[sv/mbp_pkg.sv]
`timescale 1ns / 1ps

package mbp_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 2048;
    localparam int WEIGHT_W    = 32;
    localparam int NODE_W      = 11;
    localparam int NODE_IDX_W  = $clog2(MAX_NODES);
    localparam int SIZE_W      = $clog2(MAX_NODES + 1);
    localparam int EDGE_IDX_W  = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W  = $clog2(MAX_EDGES + 1);

    typedef struct packed {
        logic [NODE_W-1:0]   u;
        logic [NODE_W-1:0]   v;
        logic [WEIGHT_W-1:0] w;
    } edge_t;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] parent;
        logic [SIZE_W-1:0]     size;
    } uf_entry_t;

endpackage

[sv/mbp_ram.sv]
`timescale 1ns / 1ps

module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/max_bottleneck_path_unit.sv]
`timescale 1ns / 1ps

// maximum bottleneck path between node 1 and node node_count
// input channel (in_valid / in_stall): one edge item per cycle while loading.
// an item with last_edge set is stored and starts the computation; in_stall
// stays high until the result has been placed in the output register.
// output channel (out_valid / out_stall): one result item per graph, held in
// an output register; a stalled result keeps its value, and a new graph can
// be loaded while it waits.
// cfg_wr_en / cfg_wr_data write node_count (reset 1); write it only when idle.
// the answer is found by a bitwise threshold search: one pass with threshold
// zero, then one pass per weight bit. each pass clears the union-find memory
// of the n nodes, then reads every stored edge and, for an edge whose ends
// are in range and whose weight meets the threshold, walks the union-find
// memory for its endpoints (depth at most log2 n thanks to union by size) and
// merges their sets if they differ; last it finds the roots of nodes 1 and n.
// a single node graph is answered without a search.
// both memories have a registered read, which sets the step pace.
// rst_n (asynchronous) empties the edge store and drops any pending result.

module max_bottleneck_path_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mbp_pkg::NODE_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mbp_pkg::NODE_W-1:0]     endpoint_u,
    input  logic [mbp_pkg::NODE_W-1:0]     endpoint_v,
    input  logic [mbp_pkg::WEIGHT_W-1:0]   edge_weight,
    input  logic                           last_edge,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           path_found,
    output logic [mbp_pkg::WEIGHT_W-1:0]   bottleneck
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_UNION_A,
        S_UNION_B,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        R_EDGE_A,
        R_EDGE_B,
        R_TERM_A,
        R_TERM_B
    } role_t;

    localparam int NW = mbp_pkg::NODE_W;
    localparam int IW = mbp_pkg::NODE_IDX_W;
    localparam int SW = mbp_pkg::SIZE_W;
    localparam int WW = mbp_pkg::WEIGHT_W;
    localparam int EW = mbp_pkg::EDGE_IDX_W;
    localparam int CW = mbp_pkg::EDGE_CNT_W;

    state_t              state_reg, state_next;
    role_t               role_reg, role_next;
    logic [NW-1:0]       node_count_reg, node_count_next;
    logic [NW-1:0]       nn_reg, nn_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [CW-1:0]       e_idx_reg, e_idx_next;
    logic [IW-1:0]       clr_idx_reg, clr_idx_next;
    logic [IW-1:0]       f_node_reg, f_node_next;
    logic [IW-1:0]       v_idx_reg, v_idx_next;
    logic [IW-1:0]       root_a_reg, root_a_next;
    logic [SW-1:0]       size_a_reg, size_a_next;
    logic [IW-1:0]       root_b_reg, root_b_next;
    logic [SW-1:0]       size_b_reg, size_b_next;
    logic [WW-1:0]       thr_reg, thr_next;
    logic [WW-1:0]       mask_reg, mask_next;
    logic                res_found_reg, res_found_next;
    logic [WW-1:0]       res_value_reg, res_value_next;
    logic                out_valid_reg, out_valid_next;
    logic                path_found_reg, path_found_next;
    logic [WW-1:0]       bottleneck_reg, bottleneck_next;

    logic                in_accept;
    logic                edge_we;
    mbp_pkg::edge_t      edge_wdata, edge_rdata;
    logic                uf_we;
    logic [IW-1:0]       uf_waddr;
    mbp_pkg::uf_entry_t  uf_wdata, uf_rdata;

    logic [IW-1:0]       nn_last;
    logic [WW-1:0]       test_thr;
    logic                edge_ok;
    logic                a_big;
    logic [IW-1:0]       big_root, small_root;
    logic [SW-1:0]       small_size;
    logic                conn;
    logic [WW-1:0]       new_thr;

    assign in_stall   = (state_reg != S_LOAD);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign path_found = path_found_reg;
    assign bottleneck = bottleneck_reg;

    assign edge_we    = in_accept && (total_reg < CW'(mbp_pkg::MAX_EDGES));
    assign edge_wdata = '{u: endpoint_u, v: endpoint_v, w: edge_weight};

    mbp_ram #(
        .WIDTH ($bits(mbp_pkg::edge_t)),
        .DEPTH (mbp_pkg::MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (total_reg[EW-1:0]),
        .wdata (edge_wdata),
        .raddr (e_idx_reg[EW-1:0]),
        .rdata (edge_rdata)
    );

    mbp_ram #(
        .WIDTH ($bits(mbp_pkg::uf_entry_t)),
        .DEPTH (mbp_pkg::MAX_NODES)
    ) u_uf_ram (
        .clk   (clk),
        .we    (uf_we),
        .waddr (uf_waddr),
        .wdata (uf_wdata),
        .raddr (f_node_reg),
        .rdata (uf_rdata)
    );

    assign nn_last  = IW'(nn_reg - NW'(1));
    assign test_thr = thr_reg | mask_reg;
    assign edge_ok  = (edge_rdata.u != '0) && (edge_rdata.u <= nn_reg)
                   && (edge_rdata.v != '0) && (edge_rdata.v <= nn_reg)
                   && (edge_rdata.w >= test_thr);

    // union by size: the smaller set hangs below the larger root
    assign a_big      = !(size_a_reg < size_b_reg);
    assign big_root   = a_big ? root_a_reg : root_b_reg;
    assign small_root = a_big ? root_b_reg : root_a_reg;
    assign small_size = a_big ? size_b_reg : size_a_reg;

    assign conn    = (f_node_reg == root_a_reg);
    assign new_thr = conn ? test_thr : thr_reg;

    always_comb
    begin
        uf_we    = 1'b0;
        uf_waddr = clr_idx_reg;
        uf_wdata = '{parent: clr_idx_reg, size: SW'(1)};
        case (state_reg)
            S_CLEAR:
            begin
                uf_we = 1'b1;
            end
            S_UNION_A:
            begin
                uf_we    = 1'b1;
                uf_waddr = small_root;
                uf_wdata = '{parent: big_root, size: small_size};
            end
            S_UNION_B:
            begin
                uf_we    = 1'b1;
                uf_waddr = big_root;
                uf_wdata = '{parent: big_root, size: SW'(size_a_reg + size_b_reg)};
            end
            default:
            begin
                uf_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        role_next       = role_reg;
        node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;
        nn_next         = nn_reg;
        total_next      = total_reg;
        e_idx_next      = e_idx_reg;
        clr_idx_next    = clr_idx_reg;
        f_node_next     = f_node_reg;
        v_idx_next      = v_idx_reg;
        root_a_next     = root_a_reg;
        size_a_next     = size_a_reg;
        root_b_next     = root_b_reg;
        size_b_next     = size_b_reg;
        thr_next        = thr_reg;
        mask_next       = mask_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        path_found_next = path_found_reg;
        bottleneck_next = bottleneck_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (edge_we)
                    begin
                        total_next = total_reg + CW'(1);
                    end
                    if (last_edge)
                    begin
                        if (node_count_reg == '0)
                        begin
                            nn_next = NW'(1);
                        end
                        else if (node_count_reg > NW'(mbp_pkg::MAX_NODES))
                        begin
                            nn_next = NW'(mbp_pkg::MAX_NODES);
                        end
                        else
                        begin
                            nn_next = node_count_reg;
                        end
                        thr_next     = '0;
                        mask_next    = '0;
                        clr_idx_next = '0;
                        if (node_count_reg <= NW'(1))
                        begin
                            res_found_next = 1'b1;
                            res_value_next = '1;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                if (clr_idx_reg == nn_last)
                begin
                    e_idx_next = '0;
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IW'(1);
                end
            end
            S_EDGE_RD:
            begin
                if (e_idx_reg == total_reg)
                begin
                    f_node_next = '0;
                    role_next   = R_TERM_A;
                    state_next  = S_FIND_RD;
                end
                else
                begin
                    state_next = S_EDGE_CHK;
                end
            end
            S_EDGE_CHK:
            begin
                if (edge_ok)
                begin
                    f_node_next = IW'(edge_rdata.u - NW'(1));
                    v_idx_next  = IW'(edge_rdata.v - NW'(1));
                    role_next   = R_EDGE_A;
                    state_next  = S_FIND_RD;
                end
                else
                begin
                    e_idx_next = e_idx_reg + CW'(1);
                    state_next = S_EDGE_RD;
                end
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (uf_rdata.parent != f_node_reg)
                begin
                    f_node_next = uf_rdata.parent;
                    state_next  = S_FIND_RD;
                end
                else
                begin
                    case (role_reg)
                        R_EDGE_A:
                        begin
                            root_a_next = f_node_reg;
                            size_a_next = uf_rdata.size;
                            f_node_next = v_idx_reg;
                            role_next   = R_EDGE_B;
                            state_next  = S_FIND_RD;
                        end
                        R_EDGE_B:
                        begin
                            if (conn)
                            begin
                                e_idx_next = e_idx_reg + CW'(1);
                                state_next = S_EDGE_RD;
                            end
                            else
                            begin
                                root_b_next = f_node_reg;
                                size_b_next = uf_rdata.size;
                                state_next  = S_UNION_A;
                            end
                        end
                        R_TERM_A:
                        begin
                            root_a_next = f_node_reg;
                            f_node_next = nn_last;
                            role_next   = R_TERM_B;
                            state_next  = S_FIND_RD;
                        end
                        default:
                        begin
                            clr_idx_next = '0;
                            if (mask_reg == '0)
                            begin
                                // existence pass with threshold zero
                                if (conn)
                                begin
                                    mask_next  = {1'b1, {(WW-1){1'b0}}};
                                    state_next = S_CLEAR;
                                end
                                else
                                begin
                                    res_found_next = 1'b0;
                                    res_value_next = '0;
                                    state_next     = S_RESULT;
                                end
                            end
                            else
                            begin
                                thr_next = new_thr;
                                if (mask_reg[0])
                                begin
                                    res_found_next = 1'b1;
                                    res_value_next = new_thr;
                                    state_next     = S_RESULT;
                                end
                                else
                                begin
                                    mask_next  = mask_reg >> 1;
                                    state_next = S_CLEAR;
                                end
                            end
                        end
                    endcase
                end
            end
            S_UNION_A:
            begin
                state_next = S_UNION_B;
            end
            S_UNION_B:
            begin
                e_idx_next = e_idx_reg + CW'(1);
                state_next = S_EDGE_RD;
            end
            S_RESULT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    path_found_next = res_found_reg;
                    bottleneck_next = res_value_reg;
                    total_next      = '0;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            node_count_reg <= NW'(1);
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            path_found_reg <= 1'b0;
            bottleneck_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            path_found_reg <= path_found_next;
            bottleneck_reg <= bottleneck_next;
        end
    end

    always_ff @(posedge clk)
    begin
        role_reg       <= role_next;
        nn_reg         <= nn_next;
        e_idx_reg      <= e_idx_next;
        clr_idx_reg    <= clr_idx_next;
        f_node_reg     <= f_node_next;
        v_idx_reg      <= v_idx_next;
        root_a_reg     <= root_a_next;
        size_a_reg     <= size_a_next;
        root_b_reg     <= root_b_next;
        size_b_reg     <= size_b_next;
        thr_reg        <= thr_next;
        mask_reg       <= mask_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
    end

endmodule

[sv/mbp_checker.sv]
`timescale 1ns / 1ps

module mbp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         last_edge,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         path_found,
    input logic [mbp_pkg::WEIGHT_W-1:0] bottleneck
);

    // a waiting result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(path_found) && $stable(bottleneck))
    else $error("stalled result changed");

    // not-found results carry a zero bottleneck
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !path_found |-> bottleneck == '0)
    else $error("not-found result with nonzero bottleneck");

    // the last edge of a graph starts the compute phase
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_edge |=> in_stall)
    else $error("input taken right after last edge");

    // a new result appears only after the input side was busy computing
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without compute phase");

endmodule

bind max_bottleneck_path_unit mbp_checker u_mbp_checker (.*);
